>>> rtl/core/ansi_escape_sequence_parser_assert.svh
// Assertion helpers shared by the parser's modules.
`ifndef ANSI_ESCAPE_SEQUENCE_PARSER_ASSERT_SVH
`define ANSI_ESCAPE_SEQUENCE_PARSER_ASSERT_SVH

// Same-cycle implication.
`define AESP_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define AESP_ASSERT_NXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/aesp_pkg.sv
package aesp_pkg;

   localparam int MAX_PARAMS_DEF = 16;
   localparam int QUEUE_DEPTH    = 4;

   // Bytes the parser recognizes
   localparam logic [7:0] CH_ESC      = 8'h1B;
   localparam logic [7:0] CH_BEL      = 8'h07;
   localparam logic [7:0] CH_LBRACKET = 8'h5B;
   localparam logic [7:0] CH_RBRACKET = 8'h5D;
   localparam logic [7:0] CH_SEMI     = 8'h3B;
   localparam logic [7:0] CH_ZERO     = 8'h30;
   localparam logic [7:0] CH_NINE     = 8'h39;
   localparam logic [7:0] FINAL_LO    = 8'h40;
   localparam logic [7:0] FINAL_HI    = 8'h7E;

   // CSI finals
   localparam logic [7:0] FIN_UP      = 8'h41;
   localparam logic [7:0] FIN_DOWN    = 8'h42;
   localparam logic [7:0] FIN_RIGHT   = 8'h43;
   localparam logic [7:0] FIN_LEFT    = 8'h44;
   localparam logic [7:0] FIN_HOME    = 8'h48;
   localparam logic [7:0] FIN_HVP     = 8'h66;
   localparam logic [7:0] FIN_ED      = 8'h4A;
   localparam logic [7:0] FIN_EL      = 8'h4B;
   localparam logic [7:0] FIN_SGR     = 8'h6D;
   localparam logic [7:0] FIN_SAVE    = 8'h73;
   localparam logic [7:0] FIN_RESTORE = 8'h75;

   localparam logic [19:0] SAT_LIMIT  = 20'h0FFFF;
   localparam logic [3:0]  FG_DEFAULT = 4'hF;
   localparam logic [3:0]  BG_DEFAULT = 4'h0;

   // SGR codes
   localparam logic [15:0] SGR_RESET  = 16'd0;
   localparam logic [15:0] SGR_BOLD   = 16'd1;
   localparam logic [15:0] SGR_FG_LO  = 16'd30;
   localparam logic [15:0] SGR_FG_HI  = 16'd37;
   localparam logic [15:0] SGR_FG_DEF = 16'd39;
   localparam logic [15:0] SGR_BG_LO  = 16'd40;
   localparam logic [15:0] SGR_BG_HI  = 16'd47;
   localparam logic [15:0] SGR_BG_DEF = 16'd49;
   localparam logic [15:0] SGR_FGB_LO = 16'd90;
   localparam logic [15:0] SGR_FGB_HI = 16'd97;
   localparam logic [15:0] SGR_BGB_LO = 16'd100;
   localparam logic [15:0] SGR_BGB_HI = 16'd107;

   typedef enum logic [1:0] {
      PS_GROUND,
      PS_ESC,
      PS_CSI,
      PS_OSC
   } parse_state_type;

   typedef enum logic [1:0] {
      FR_IDLE,
      FR_READ,
      FR_PUSH
   } front_state_type;

   typedef enum logic [2:0] {
      CMD_PUT_CHAR      = 3'd0,
      CMD_SET_CURSOR    = 3'd1,
      CMD_ERASE_DISPLAY = 3'd2,
      CMD_ERASE_LINE    = 3'd3,
      CMD_SET_COLOR     = 3'd4
   } cmd_type;

   typedef enum logic [3:0] {
      OP_PUT,
      OP_UP,
      OP_DOWN,
      OP_RIGHT,
      OP_LEFT,
      OP_HOME,
      OP_ERASE_DISP,
      OP_ERASE_LINE,
      OP_SGR,
      OP_SAVE,
      OP_RESTORE
   } op_type;

   // One queued operation for the back end
   typedef struct packed {
      op_type      op;
      logic        last;   // SGR: final parameter of the sequence
      logic [7:0]  chr;
      logic [15:0] row;
      logic [15:0] col;
      logic [15:0] arg0;   // first parameter, or SGR code
      logic [15:0] arg1;   // second parameter
   } entry_type;

   // Apply one SGR code; returns {fg, bg}
   function automatic logic [7:0] sgr_apply(input logic [3:0]  fg,
                                            input logic [3:0]  bg,
                                            input logic [15:0] p);
      logic [3:0]  fg_n;
      logic [3:0]  bg_n;
      logic [15:0] off_fg;
      logic [15:0] off_bg;
      logic [15:0] off_fgb;
      logic [15:0] off_bgb;
      fg_n    = fg;
      bg_n    = bg;
      off_fg  = p - SGR_FG_LO;
      off_bg  = p - SGR_BG_LO;
      off_fgb = p - SGR_FGB_LO;
      off_bgb = p - SGR_BGB_LO;
      if (p == SGR_RESET) begin
         fg_n = FG_DEFAULT;
         bg_n = BG_DEFAULT;
      end else if (p == SGR_BOLD) begin
         fg_n = {1'b1, fg[2:0]};
      end else if (p >= SGR_FG_LO && p <= SGR_FG_HI) begin
         fg_n = {fg[3], off_fg[2:0]};
      end else if (p == SGR_FG_DEF) begin
         fg_n = {fg[3], 3'b111};
      end else if (p >= SGR_BG_LO && p <= SGR_BG_HI) begin
         bg_n = {1'b0, off_bg[2:0]};
      end else if (p == SGR_BG_DEF) begin
         bg_n = BG_DEFAULT;
      end else if (p >= SGR_FGB_LO && p <= SGR_FGB_HI) begin
         fg_n = {1'b1, off_fgb[2:0]};
      end else if (p >= SGR_BGB_LO && p <= SGR_BGB_HI) begin
         bg_n = {1'b1, off_bgb[2:0]};
      end
      return {fg_n, bg_n};
   endfunction

endpackage

>>> rtl/core/aesp_queue.sv
`include "ansi_escape_sequence_parser_assert.svh"

module aesp_queue
   import aesp_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   output logic      full,
   input  logic      pop,
   output logic      valid,
   output entry_type head
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   entry_type        slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   assign full  = (cnt_ff == CNT_W'(QUEUE_DEPTH));
   assign valid = (cnt_ff != '0);
   assign head  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      cnt_in    = cnt_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   `AESP_ASSERT_IMP(a_no_push_full, clock, reset, push, !full, "push into full queue")
   `AESP_ASSERT_IMP(a_no_pop_empty, clock, reset, pop, valid, "pop from empty queue")

endmodule

>>> rtl/core/aesp_front.sv
`include "ansi_escape_sequence_parser_assert.svh"

module aesp_front
   import aesp_pkg::*;
#(
   parameter int MAX_PARAMS = MAX_PARAMS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_byte_in,
   input  logic [15:0] req_cursor_row,
   input  logic [15:0] req_cursor_col,
   output logic        push,
   output entry_type   push_entry,
   input  logic        q_full
);

   localparam int CNT_W = $clog2(MAX_PARAMS + 1);
   localparam int IDX_W = $clog2(MAX_PARAMS);

   parse_state_type  ps_ff, ps_in;
   front_state_type  fs_ff, fs_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             open_ff, open_in;
   logic [15:0]      acc_ff, acc_in;    // value of the open slot
   logic [15:0]      p0_ff, p0_in;      // copies of slots 0 and 1
   logic [15:0]      p1_ff, p1_in;
   logic [IDX_W-1:0] idx_ff, idx_in;    // SGR walk position

   logic [15:0]      param_mem [MAX_PARAMS];
   logic [15:0]      rdata_ff;

   logic             accept;
   logic             is_digit, is_final, cnt_zero, cnt_max, walk_last;
   logic [3:0]       digit;
   logic [7:0]       digit_wide;
   logic [IDX_W-1:0] cur_slot, sep_slot;
   logic [15:0]      base, acc_new, first, second;
   logic [19:0]      prod;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [15:0]      wr_data;

   assign req_stall = (fs_ff != FR_IDLE) || q_full;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      is_digit   = (req_byte_in >= CH_ZERO) && (req_byte_in <= CH_NINE);
      is_final   = (req_byte_in >= FINAL_LO) && (req_byte_in <= FINAL_HI);
      digit_wide = req_byte_in - CH_ZERO;
      digit      = digit_wide[3:0];
      cnt_zero   = (count_ff == '0);
      cnt_max    = (count_ff == CNT_W'(MAX_PARAMS));
      cur_slot   = cnt_zero ? '0 : IDX_W'(count_ff - CNT_W'(1));
      sep_slot   = IDX_W'(count_ff);
      base       = (open_ff && !cnt_zero) ? acc_ff : '0;
      // base * 10 + digit, saturating
      prod       = ({4'b0, base} << 3) + ({4'b0, base} << 1) + {16'b0, digit};
      acc_new    = (prod > SAT_LIMIT) ? 16'hFFFF : prod[15:0];
      first      = cnt_zero ? '0 : p0_ff;
      second     = (count_ff > CNT_W'(1)) ? p1_ff : '0;
      walk_last  = ((CNT_W'(idx_ff) + CNT_W'(1)) == count_ff);
   end

   // Next state
   always_comb begin
      ps_in    = ps_ff;
      fs_in    = fs_ff;
      count_in = count_ff;
      open_in  = open_ff;
      acc_in   = acc_ff;
      p0_in    = p0_ff;
      p1_in    = p1_ff;
      idx_in   = idx_ff;
      unique case (fs_ff)
         FR_IDLE: begin
            if (accept) begin
               unique case (ps_ff)
                  PS_GROUND: begin
                     if (req_byte_in == CH_ESC) begin
                        ps_in = PS_ESC;
                     end
                  end
                  PS_ESC: begin
                     if (req_byte_in == CH_LBRACKET) begin
                        ps_in    = PS_CSI;
                        count_in = '0;
                        open_in  = 1'b0;
                     end else if (req_byte_in == CH_RBRACKET) begin
                        ps_in = PS_OSC;
                     end else begin
                        ps_in = PS_GROUND;
                     end
                  end
                  PS_CSI: begin
                     if (is_digit) begin
                        count_in = cnt_zero ? CNT_W'(1) : count_ff;
                        open_in  = 1'b1;
                        acc_in   = acc_new;
                        if (cur_slot == IDX_W'(0)) begin
                           p0_in = acc_new;
                        end
                        if (cur_slot == IDX_W'(1)) begin
                           p1_in = acc_new;
                        end
                     end else if (req_byte_in == CH_SEMI) begin
                        if (!cnt_max) begin
                           count_in = count_ff + CNT_W'(1);
                           open_in  = 1'b0;
                           if (sep_slot == IDX_W'(0)) begin
                              p0_in = '0;
                           end
                           if (sep_slot == IDX_W'(1)) begin
                              p1_in = '0;
                           end
                        end
                     end else if (is_final) begin
                        ps_in = PS_GROUND;
                        if (req_byte_in == FIN_SGR && !cnt_zero) begin
                           fs_in  = FR_READ;
                           idx_in = '0;
                        end
                     end
                  end
                  PS_OSC: begin
                     if (req_byte_in == CH_BEL || req_byte_in == CH_ESC) begin
                        ps_in = PS_GROUND;
                     end
                  end
                  default: ps_in = PS_GROUND;
               endcase
            end
         end
         FR_READ: fs_in = FR_PUSH;
         FR_PUSH: begin
            if (!q_full) begin
               if (walk_last) begin
                  fs_in = FR_IDLE;
               end else begin
                  idx_in = idx_ff + IDX_W'(1);
                  fs_in  = FR_READ;
               end
            end
         end
         default: fs_in = FR_IDLE;
      endcase
   end

   // Outputs: queue pushes and parameter writes
   always_comb begin
      push            = 1'b0;
      push_entry      = '0;
      push_entry.op   = OP_PUT;
      push_entry.row  = req_cursor_row;
      push_entry.col  = req_cursor_col;
      push_entry.arg0 = first;
      push_entry.arg1 = second;
      push_entry.last = 1'b1;
      wr_en           = 1'b0;
      wr_addr         = cur_slot;
      wr_data         = acc_new;
      unique case (fs_ff)
         FR_IDLE: begin
            if (accept && ps_ff == PS_GROUND && req_byte_in != CH_ESC) begin
               push           = 1'b1;
               push_entry.op  = OP_PUT;
               push_entry.chr = req_byte_in;
            end
            if (accept && ps_ff == PS_CSI) begin
               if (is_digit) begin
                  wr_en = 1'b1;
               end else if (req_byte_in == CH_SEMI) begin
                  wr_en   = !cnt_max;
                  wr_addr = sep_slot;
                  wr_data = '0;
               end else if (is_final) begin
                  unique case (req_byte_in)
                     FIN_UP: begin
                        push          = 1'b1;
                        push_entry.op = OP_UP;
                     end
                     FIN_DOWN: begin
                        push          = 1'b1;
                        push_entry.op = OP_DOWN;
                     end
                     FIN_RIGHT: begin
                        push          = 1'b1;
                        push_entry.op = OP_RIGHT;
                     end
                     FIN_LEFT: begin
                        push          = 1'b1;
                        push_entry.op = OP_LEFT;
                     end
                     FIN_HOME, FIN_HVP: begin
                        push          = 1'b1;
                        push_entry.op = OP_HOME;
                     end
                     FIN_ED: begin
                        push          = 1'b1;
                        push_entry.op = OP_ERASE_DISP;
                     end
                     FIN_EL: begin
                        push          = 1'b1;
                        push_entry.op = OP_ERASE_LINE;
                     end
                     FIN_SGR: begin
                        // empty SGR acts as a single reset code
                        push            = cnt_zero;
                        push_entry.op   = OP_SGR;
                        push_entry.arg0 = SGR_RESET;
                     end
                     FIN_SAVE: begin
                        push          = 1'b1;
                        push_entry.op = OP_SAVE;
                     end
                     FIN_RESTORE: begin
                        push          = 1'b1;
                        push_entry.op = OP_RESTORE;
                     end
                     default: push = 1'b0;
                  endcase
               end
            end
         end
         FR_PUSH: begin
            push            = !q_full;
            push_entry.op   = OP_SGR;
            push_entry.arg0 = rdata_ff;
            push_entry.last = walk_last;
         end
         default: push = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ps_ff    <= PS_GROUND;
         fs_ff    <= FR_IDLE;
         count_ff <= '0;
         open_ff  <= 1'b0;
      end else begin
         ps_ff    <= ps_in;
         fs_ff    <= fs_in;
         count_ff <= count_in;
         open_ff  <= open_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      p0_ff  <= p0_in;
      p1_ff  <= p1_in;
      idx_ff <= idx_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         param_mem[wr_addr] <= wr_data;
      end
      rdata_ff <= param_mem[idx_ff];
   end

   `AESP_ASSERT_IMP(a_walk_in_range, clock, reset, fs_ff != FR_IDLE, CNT_W'(idx_ff) < count_ff, "SGR walk past last parameter")
   `AESP_ASSERT_NXT(a_walk_ends_ground, clock, reset, fs_ff == FR_IDLE && fs_in == FR_READ, ps_ff == PS_GROUND, "SGR walk left parser outside ground")

endmodule

>>> rtl/core/aesp_back.sv
`include "ansi_escape_sequence_parser_assert.svh"

module aesp_back
   import aesp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        q_valid,
   input  entry_type   q_head,
   output logic        pop,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_command,
   output logic [7:0]  rsp_char_out,
   output logic [15:0] rsp_row_out,
   output logic [15:0] rsp_col_out,
   output logic [15:0] rsp_erase_mode,
   output logic [3:0]  rsp_fg_color,
   output logic [3:0]  rsp_bg_color
);

   logic        valid_ff, valid_in;
   cmd_type     cmd_ff, cmd_in;
   logic [7:0]  chr_ff, chr_in;
   logic [15:0] row_ff, row_in;
   logic [15:0] col_ff, col_in;
   logic [15:0] mode_ff, mode_in;
   logic [3:0]  fgo_ff, fgo_in;
   logic [3:0]  bgo_ff, bgo_in;
   logic [3:0]  fg_ff, fg_in;
   logic [3:0]  bg_ff, bg_in;
   logic [15:0] saved_row_ff, saved_row_in;
   logic [15:0] saved_col_ff, saved_col_in;

   logic        out_free;
   logic [15:0] n, up_row, down_row, right_col, left_col, home_row, home_col;
   logic [7:0]  sgr_res;

   assign out_free = !valid_ff || !rsp_stall;
   assign pop      = q_valid && out_free;

   always_comb begin
      n         = (q_head.arg0 != '0) ? q_head.arg0 : 16'd1;
      up_row    = (q_head.row >= n) ? q_head.row - n : '0;
      down_row  = q_head.row + n;
      right_col = q_head.col + n;
      left_col  = (q_head.col >= n) ? q_head.col - n : '0;
      home_row  = (q_head.arg0 != '0) ? q_head.arg0 - 16'd1 : '0;
      home_col  = (q_head.arg1 != '0) ? q_head.arg1 - 16'd1 : '0;
      sgr_res   = sgr_apply(fg_ff, bg_ff, q_head.arg0);
   end

   always_comb begin
      valid_in     = valid_ff;
      cmd_in       = cmd_ff;
      chr_in       = chr_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      mode_in      = mode_ff;
      fgo_in       = fgo_ff;
      bgo_in       = bgo_ff;
      fg_in        = fg_ff;
      bg_in        = bg_ff;
      saved_row_in = saved_row_ff;
      saved_col_in = saved_col_ff;
      if (out_free) begin
         valid_in = 1'b0;
      end
      if (pop) begin
         chr_in  = '0;
         row_in  = '0;
         col_in  = '0;
         mode_in = '0;
         fgo_in  = '0;
         bgo_in  = '0;
         unique case (q_head.op)
            OP_PUT: begin
               valid_in = 1'b1;
               cmd_in   = CMD_PUT_CHAR;
               chr_in   = q_head.chr;
            end
            OP_UP: begin
               valid_in = 1'b1;
               cmd_in   = CMD_SET_CURSOR;
               row_in   = up_row;
               col_in   = q_head.col;
            end
            OP_DOWN: begin
               valid_in = 1'b1;
               cmd_in   = CMD_SET_CURSOR;
               row_in   = down_row;
               col_in   = q_head.col;
            end
            OP_RIGHT: begin
               valid_in = 1'b1;
               cmd_in   = CMD_SET_CURSOR;
               row_in   = q_head.row;
               col_in   = right_col;
            end
            OP_LEFT: begin
               valid_in = 1'b1;
               cmd_in   = CMD_SET_CURSOR;
               row_in   = q_head.row;
               col_in   = left_col;
            end
            OP_HOME: begin
               valid_in = 1'b1;
               cmd_in   = CMD_SET_CURSOR;
               row_in   = home_row;
               col_in   = home_col;
            end
            OP_ERASE_DISP: begin
               valid_in = 1'b1;
               cmd_in   = CMD_ERASE_DISPLAY;
               mode_in  = q_head.arg0;
            end
            OP_ERASE_LINE: begin
               valid_in = 1'b1;
               cmd_in   = CMD_ERASE_LINE;
               mode_in  = q_head.arg0;
            end
            OP_SGR: begin
               // colors move on every code, the word goes out on the last one
               fg_in    = sgr_res[7:4];
               bg_in    = sgr_res[3:0];
               valid_in = q_head.last;
               cmd_in   = CMD_SET_COLOR;
               fgo_in   = sgr_res[7:4];
               bgo_in   = sgr_res[3:0];
            end
            OP_SAVE: begin
               saved_row_in = q_head.row;
               saved_col_in = q_head.col;
            end
            OP_RESTORE: begin
               valid_in = 1'b1;
               cmd_in   = CMD_SET_CURSOR;
               row_in   = saved_row_ff;
               col_in   = saved_col_ff;
            end
            default: valid_in = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= 1'b0;
         fg_ff        <= FG_DEFAULT;
         bg_ff        <= BG_DEFAULT;
         saved_row_ff <= '0;
         saved_col_ff <= '0;
      end else begin
         valid_ff     <= valid_in;
         fg_ff        <= fg_in;
         bg_ff        <= bg_in;
         saved_row_ff <= saved_row_in;
         saved_col_ff <= saved_col_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      chr_ff  <= chr_in;
      row_ff  <= row_in;
      col_ff  <= col_in;
      mode_ff <= mode_in;
      fgo_ff  <= fgo_in;
      bgo_ff  <= bgo_in;
   end

   assign rsp_valid      = valid_ff;
   assign rsp_command    = cmd_ff;
   assign rsp_char_out   = chr_ff;
   assign rsp_row_out    = row_ff;
   assign rsp_col_out    = col_ff;
   assign rsp_erase_mode = mode_ff;
   assign rsp_fg_color   = fgo_ff;
   assign rsp_bg_color   = bgo_ff;

   `AESP_ASSERT_NXT(a_saved_only_on_save, clock, reset, !(pop && q_head.op == OP_SAVE), $stable(saved_row_ff) && $stable(saved_col_ff), "saved cursor changed without save")

endmodule

>>> rtl/core/ansi_escape_sequence_parser.sv
// A result word is registered in the queue and then in the output register
// before it is on rsp; an SGR word also waits for the front's walk of its parameters.
// Throughput: one byte per cycle unless req_stall is raised (queue full); the front also stalls
// after an SGR final with parameters while it reads the parameter RAM, a read state then a push state per slot.
// Reset (synchronous, active high): parser to ground, parameters closed,
// colors fg 15 / bg 0, saved cursor 0,0, queue and output register empty.
module ansi_escape_sequence_parser
   import aesp_pkg::*;
#(
   parameter int MAX_PARAMS = MAX_PARAMS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // byte words in
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_byte_in,
   input  logic [15:0] req_cursor_row,
   input  logic [15:0] req_cursor_col,
   // display command words out
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_command,
   output logic [7:0]  rsp_char_out,
   output logic [15:0] rsp_row_out,
   output logic [15:0] rsp_col_out,
   output logic [15:0] rsp_erase_mode,
   output logic [3:0]  rsp_fg_color,
   output logic [3:0]  rsp_bg_color
);

   // Front: escape/CSI/OSC parser. Digits and separators update a small
   // parameter RAM plus shadow copies of slots 0 and 1, so every recognized final
   // turns into one queue entry on the cycle its byte is taken, except an SGR
   // with parameters, which walks the RAM and pushes one entry per parameter.
   //
   // Queue: short FIFO of decoded operations so the parser keeps taking
   // bytes while the output waits on rsp_stall, until the queue fills.
   //
   // Back: executes one entry per cycle into the output register unless a held
   // word is stalled; holds the color state and the saved cursor. Save and
   // non-final SGR entries produce no word.

   logic      push;
   entry_type push_entry;
   logic      q_full;
   logic      q_valid;
   entry_type q_head;
   logic      pop;

   aesp_front #(
      .MAX_PARAMS (MAX_PARAMS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_byte_in    (req_byte_in),
      .req_cursor_row (req_cursor_row),
      .req_cursor_col (req_cursor_col),
      .push           (push),
      .push_entry     (push_entry),
      .q_full         (q_full)
   );

   aesp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (pop),
      .valid      (q_valid),
      .head       (q_head)
   );

   aesp_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .q_head         (q_head),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_command    (rsp_command),
      .rsp_char_out   (rsp_char_out),
      .rsp_row_out    (rsp_row_out),
      .rsp_col_out    (rsp_col_out),
      .rsp_erase_mode (rsp_erase_mode),
      .rsp_fg_color   (rsp_fg_color),
      .rsp_bg_color   (rsp_bg_color)
   );

endmodule
